>>> rtl/gcr_pkg.sv
// Shared types and constants for the gradient color ramp lookup.
package gcr_pkg;

    localparam int STOP_REGS = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 40;
    localparam int POS_W     = 16;
    localparam int CHAN_W    = 8;
    localparam int NUM_CH    = 3;
    localparam int NUM_W     = POS_W + CHAN_W;
    localparam int DIV_STEPS = CHAN_W;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic [NUM_CH-1:0][CHAN_W-1:0] t_color;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic             fixed;
        t_color           fix_col;
        logic             found_lo;
        logic [POS_W-1:0] lo_pos;
        t_color           lo_col;
        logic [POS_W-1:0] hi_pos;
        t_color           hi_col;
    } t_search;

    typedef struct packed {
        logic                         byp;
        logic [POS_W-1:0]             w;
        logic [NUM_CH-1:0][NUM_W-1:0] rem;
        t_color                       col;
    } t_div;

endpackage

>>> rtl/gradient_color_ramp_lookup_unit.sv
// Top level of the gradient color ramp lookup: stop search, blend and output buffering.
//
// Usage: write the stops through the config port (i_cfg_we, i_cfg_idx, i_cfg_data) while
// the unit is idle; bits 15:0 hold the stop position, then red, green and blue bytes.
// Stops must be in nondecreasing position order, unused stops padded with the last one.
// Input channel: i_valid/o_stall carry one 16-bit position per beat. Output channel:
// o_valid/i_stall carry one RGB color per beat, in input order.
// Pipeline: each position passes the stop search chain, one multiply, one sum, eight
// divider steps (one quotient bit each) and the output register before its color
// appears on o_valid.
// Throughput: one beat per cycle while the skid is empty; all stages advance together.
// Receiver stall: the output register holds its beat and one more beat lands in a skid
// register; while the skid register is full the pipeline freezes and o_stall is high.
// Reset clears all stops to zero and empties the pipeline and output buffers.
module gradient_color_ramp_lookup_unit #(
    parameter int NUM_STOPS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gcr_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [gcr_pkg::POS_W-1:0]       i_position,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [gcr_pkg::CHAN_W-1:0]      o_red,
    output logic [gcr_pkg::CHAN_W-1:0]      o_green,
    output logic [gcr_pkg::CHAN_W-1:0]      o_blue
);

    localparam int DIV_N = gcr_pkg::DIV_STEPS;

    logic [gcr_pkg::CFG_W-1:0]    r_stop [NUM_STOPS];

    logic                         en;
    logic                         srch_valid [NUM_STOPS+1];
    gcr_pkg::t_search             srch       [NUM_STOPS+1];
    gcr_pkg::t_search             srch_in;
    gcr_pkg::t_search             srch_out;

    logic                                           r_m_valid;
    logic                                           r_m_byp;
    gcr_pkg::t_color                                r_m_col;
    logic [gcr_pkg::NUM_CH-1:0][gcr_pkg::NUM_W-1:0] r_m_prod_a;
    logic [gcr_pkg::NUM_CH-1:0][gcr_pkg::NUM_W-1:0] r_m_prod_b;
    logic [gcr_pkg::POS_W-1:0]                      r_m_w;
    logic                                           n_m_byp;
    gcr_pkg::t_color                                n_m_col;
    logic [gcr_pkg::NUM_CH-1:0][gcr_pkg::NUM_W-1:0] n_m_prod_a;
    logic [gcr_pkg::NUM_CH-1:0][gcr_pkg::NUM_W-1:0] n_m_prod_b;
    logic [gcr_pkg::POS_W-1:0]                      d_lo;
    logic [gcr_pkg::POS_W-1:0]                      d_hi;

    logic                         r_s_valid;
    gcr_pkg::t_div                r_s;
    gcr_pkg::t_div                n_s;

    logic                         div_valid [DIV_N+1];
    gcr_pkg::t_div                div       [DIV_N+1];

    logic                         r_out_valid;
    gcr_pkg::t_color              r_out_col;
    logic                         r_skid_full;
    gcr_pkg::t_color              r_skid_col;
    logic                         out_free;
    logic                         push;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_STOPS; g++) begin
                r_stop[g] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int g = 0; g < NUM_STOPS; g++) begin
                if (i_cfg_idx == gcr_pkg::CFG_IDX_W'(g)) begin
                    r_stop[g] <= i_cfg_data;
                end
            end
        end
    end

    assign en      = !r_skid_full;
    assign o_stall = r_skid_full;

    // stop search chain
    always_comb begin
        srch_in   = '0;
        srch_in.x = i_position;
    end

    assign srch_valid[0] = i_valid;
    assign srch[0]       = srch_in;

    for (genvar g = 0; g < NUM_STOPS; g++) begin : g_stop
        gcr_stop_cell #(
            .IS_FIRST (g == 0),
            .IS_LAST  (g == NUM_STOPS - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (srch_valid[g]),
            .i_srch  (srch[g]),
            .i_stop  (r_stop[g]),
            .o_valid (srch_valid[g+1]),
            .o_srch  (srch[g+1])
        );
    end

    assign srch_out = srch[NUM_STOPS];

    // weight products
    always_comb begin
        n_m_byp = srch_out.fixed || (srch_out.lo_pos <= srch_out.hi_pos);
        n_m_col = srch_out.fixed ? srch_out.fix_col : srch_out.lo_col;
        d_lo    = srch_out.x - srch_out.hi_pos;
        d_hi    = srch_out.lo_pos - srch_out.x;
        for (int ch = 0; ch < gcr_pkg::NUM_CH; ch++) begin
            n_m_prod_a[ch] = gcr_pkg::NUM_W'(srch_out.lo_col[ch]) * gcr_pkg::NUM_W'(d_lo);
            n_m_prod_b[ch] = gcr_pkg::NUM_W'(srch_out.hi_col[ch]) * gcr_pkg::NUM_W'(d_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= srch_valid[NUM_STOPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_byp    <= n_m_byp;
            r_m_col    <= n_m_col;
            r_m_prod_a <= n_m_prod_a;
            r_m_prod_b <= n_m_prod_b;
            r_m_w      <= srch_out.lo_pos - srch_out.hi_pos;
        end
    end

    // rounded numerator
    always_comb begin
        n_s     = '0;
        n_s.byp = r_m_byp;
        n_s.w   = r_m_w;
        n_s.col = r_m_byp ? r_m_col : '0;
        for (int ch = 0; ch < gcr_pkg::NUM_CH; ch++) begin
            n_s.rem[ch] = r_m_prod_a[ch] + r_m_prod_b[ch] + gcr_pkg::NUM_W'(r_m_w >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (en) begin
            r_s_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s <= n_s;
        end
    end

    // divider chain, most significant quotient bit first
    assign div_valid[0] = r_s_valid;
    assign div[0]       = r_s;

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        gcr_div_cell #(
            .SHIFT (DIV_N - 1 - g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[g]),
            .i_div   (div[g]),
            .o_valid (div_valid[g+1]),
            .o_div   (div[g+1])
        );
    end

    // output register and skid
    assign out_free = !r_out_valid || !i_stall;
    assign push     = en && div_valid[DIV_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (out_free) begin
            if (r_skid_full) begin
                r_out_valid <= 1'b1;
                r_skid_full <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_full) begin
                r_out_col <= r_skid_col;
            end else if (push) begin
                r_out_col <= div[DIV_N].col;
            end
        end else if (push) begin
            r_skid_col <= div[DIV_N].col;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out_col[gcr_pkg::CH_RED];
    assign o_green = r_out_col[gcr_pkg::CH_GREEN];
    assign o_blue  = r_out_col[gcr_pkg::CH_BLUE];

endmodule

>>> rtl/gcr_stop_cell.sv
// One stop of the search chain: compares the position with its stop and hands the result on.
module gcr_stop_cell #(
    parameter bit IS_FIRST = 1'b0,
    parameter bit IS_LAST  = 1'b0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  gcr_pkg::t_search            i_srch,
    input  logic [gcr_pkg::CFG_W-1:0]   i_stop,
    output logic                        o_valid,
    output gcr_pkg::t_search            o_srch
);

    logic                         r_valid;
    gcr_pkg::t_search             r_srch;
    gcr_pkg::t_search             n_srch;
    logic [gcr_pkg::POS_W-1:0]    pos;
    gcr_pkg::t_color              col;

    assign pos = i_stop[gcr_pkg::POS_W-1:0];
    assign col = gcr_pkg::t_color'(i_stop[gcr_pkg::CFG_W-1:gcr_pkg::POS_W]);

    always_comb begin
        n_srch = i_srch;
        if (IS_FIRST) begin
            n_srch.fixed   = (i_srch.x <= pos);
            n_srch.fix_col = col;
        end
        if (!i_srch.found_lo && (pos >= i_srch.x)) begin
            n_srch.found_lo = 1'b1;
            n_srch.lo_pos   = pos;
            n_srch.lo_col   = col;
        end
        if (pos <= i_srch.x) begin
            n_srch.hi_pos = pos;
            n_srch.hi_col = col;
        end
        if (IS_LAST && !n_srch.fixed && (i_srch.x >= pos)) begin
            n_srch.fixed   = 1'b1;
            n_srch.fix_col = col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_srch <= n_srch;
        end
    end

    assign o_valid = r_valid;
    assign o_srch  = r_srch;

endmodule

>>> rtl/gcr_div_cell.sv
// One quotient bit of the channel divider chain, all three channels side by side.
module gcr_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  gcr_pkg::t_div     i_div,
    output logic              o_valid,
    output gcr_pkg::t_div     o_div
);

    logic                         r_valid;
    gcr_pkg::t_div                r_div;
    gcr_pkg::t_div                n_div;
    logic [gcr_pkg::NUM_W-1:0]    dvs;

    assign dvs = gcr_pkg::NUM_W'(i_div.w) << SHIFT;

    always_comb begin
        n_div = i_div;
        for (int ch = 0; ch < gcr_pkg::NUM_CH; ch++) begin
            if (!i_div.byp && (i_div.rem[ch] >= dvs)) begin
                n_div.rem[ch]        = i_div.rem[ch] - dvs;
                n_div.col[ch][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

>>> rtl/gcr_checker.sv
// Port-level checks for the gradient color ramp lookup, bound to the top level.
module gcr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_stall,
    input  logic                            o_valid,
    input  logic                            i_stall,
    input  logic [gcr_pkg::CHAN_W-1:0]      o_red,
    input  logic [gcr_pkg::CHAN_W-1:0]      o_green,
    input  logic [gcr_pkg::CHAN_W-1:0]      o_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_red) && $stable(o_green)
            && $stable(o_blue))
        else $error("stalled output beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output beat pending");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall raised without a stalled output beat");

endmodule

bind gradient_color_ramp_lookup_unit gcr_checker u_gcr_checker (.*);
